>>> hw/rtl/dmx_pkg.sv
// ----------------------------------------------------------------------------
// DMX slot capture package
// Shared request and result types and fixed constants of the slot capture.
// ----------------------------------------------------------------------------
package dmx_pkg;

	// Number of consecutive slots decoded by this device.
	localparam int unsigned SLOT_COUNT = 7;

	// Data byte that marks the null start code after a break.
	localparam logic [7:0] NULL_START_CODE = 8'h00;

	localparam int unsigned BASE_W = 9;
	localparam int unsigned FUNC_W = 3;

	// Reset value of the base address register.
	localparam logic [BASE_W-1:0] BASE_RESET = 9'd1;

	typedef logic [FUNC_W-1:0] dmx_func_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       line_break;
	} dmx_in_t;

	typedef struct packed {
		dmx_func_t  slot_function;
		logic [7:0] slot_value;
	} dmx_out_t;

	// Slot decode result passed from the decoder to the top level.
	typedef struct packed {
		logic      hit;
		dmx_func_t slot_function;
	} dmx_match_t;

endpackage

>>> hw/rtl/dmx_slot_decode.sv
// ----------------------------------------------------------------------------
// DMX slot decoder
// Combinational next-state and slot-match logic for one received byte.
// ----------------------------------------------------------------------------
module dmx_slot_decode #(
	parameter int unsigned COUNTER_LIMIT = 1023,
	parameter int unsigned CNT_W         = 10
) (
	input  dmx_pkg::dmx_in_t                 req,
	input  logic [dmx_pkg::BASE_W-1:0]       base_address,
	input  logic [CNT_W-1:0]                 slot_counter,
	input  logic                             frame_valid,
	output logic [CNT_W-1:0]                 next_counter,
	output logic                             next_valid,
	output dmx_pkg::dmx_match_t              match
);
	import dmx_pkg::*;

	logic [CNT_W-1:0] cnt_eff;
	logic             valid_eff;
	logic [CNT_W:0]   diff;

	// A break clears the frame before the same byte is judged.
	assign cnt_eff   = req.line_break ? '0 : slot_counter;
	assign valid_eff = req.line_break ? 1'b0 : frame_valid;

	// Offset of the counter from the base address; a borrow means below base.
	assign diff = {1'b0, cnt_eff} - {1'b0, CNT_W'(base_address)};

	always_comb begin
		match.hit           = 1'b0;
		match.slot_function = diff[FUNC_W-1:0];
		next_counter        = cnt_eff;
		next_valid          = valid_eff;
		if (valid_eff) begin
			match.hit = !diff[CNT_W] && (diff[CNT_W-1:0] < CNT_W'(SLOT_COUNT));
			if (cnt_eff < CNT_W'(COUNTER_LIMIT)) begin
				next_counter = cnt_eff + CNT_W'(1);
			end
		end else if (cnt_eff == '0 && req.data_byte == NULL_START_CODE) begin
			next_valid = 1'b1;
		end
	end

endmodule

>>> hw/rtl/dmx512_slot_capture.sv
// ----------------------------------------------------------------------------
// DMX512 slot capture
// Tracks the slot number of received DMX bytes and reports the bytes that
// fall in this device's seven-slot window together with their function code.
// ----------------------------------------------------------------------------
// Timing: a request is captured in the input register at the edge that accepts
// it, and its result, if any, is then loaded into the output register once that
// register is free. Throughput: one request per cycle; the input side stalls only
// while the input register holds a request that makes a result and the output
// register is full and stalled by the receiver.
// Reset: arst_n clears the counter, frame flag and valid flags at once and
// sets base_address to 1; no clearing pass is needed.
module dmx512_slot_capture #(
	parameter int unsigned COUNTER_LIMIT = 1023
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [dmx_pkg::BASE_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  dmx_pkg::dmx_in_t            in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output dmx_pkg::dmx_out_t           out_data
);
	import dmx_pkg::*;

	// The counter must be able to hold the saturation limit itself.
	localparam int unsigned CNT_W = $clog2(COUNTER_LIMIT + 1);

	logic [BASE_W-1:0] base_q;
	logic [CNT_W-1:0]  counter_q;
	logic              frame_valid_q;

	// Input register: one request waiting to be decoded.
	logic              valid_s1;
	dmx_in_t           req_s1;

	// Output register holding one finished result.
	logic              out_valid_q;
	dmx_out_t          out_q;

	logic [CNT_W-1:0]  next_counter;
	logic              next_valid;
	dmx_match_t        match;
	logic              out_free;
	logic              adv_s1;
	logic              in_accept;

	// The base address must be written only while no request is in flight; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_wr_en) begin
			base_q <= cfg_wr_data;
		end
	end

	dmx_slot_decode #(
		.COUNTER_LIMIT (COUNTER_LIMIT),
		.CNT_W         (CNT_W)
	) u_decode (
		.req          (req_s1),
		.base_address (base_q),
		.slot_counter (counter_q),
		.frame_valid  (frame_valid_q),
		.next_counter (next_counter),
		.next_valid   (next_valid),
		.match        (match)
	);

	// The output register can take a result when it is empty or being drained.
	// A request that makes no result never waits on the output side.
	assign out_free  = !out_valid_q || !out_stall;
	assign adv_s1    = valid_s1 && (!match.hit || out_free);
	assign in_stall  = valid_s1 && !adv_s1;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_s1 <= in_data;
		end
	end

	// Frame state moves only when the decoded request leaves the input register,
	// so the next request always sees the state left by the one before it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q     <= '0;
			frame_valid_q <= 1'b0;
		end else if (adv_s1) begin
			counter_q     <= next_counter;
			frame_valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && match.hit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && match.hit) begin
			out_q.slot_function <= match.slot_function;
			out_q.slot_value    <= req_s1.data_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The counter saturates and never passes its limit.
	a_counter_limit: assert property (@(posedge clk) disable iff (!arst_n)
		counter_q <= CNT_W'(COUNTER_LIMIT))
		else $error("slot counter beyond its limit");

	// The frame flag only drops on a decoded break.
	a_valid_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(frame_valid_q) |-> $past(adv_s1 && req_s1.line_break))
		else $error("frame flag cleared without a break");

	// The counter only changes when a request is decoded.
	a_counter_move: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(counter_q) |-> $past(adv_s1))
		else $error("slot counter moved without a request");

	// The input side stalls only behind a result that cannot be delivered.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && match.hit && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

endmodule
